// ----- rtl/nomf_pkg.sv -----
// ----------------------------------------------------------------------------
// nomf_pkg: shared types and constants of the SNTP offset median filter
// Holds the request and result payloads, the status and register codes, and
// the microcode table that steps the filter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package nomf_pkg;

	// Request payload: one SNTP reply
	typedef struct packed {
		logic [31:0] header_word;
		logic [31:0] server_recv_seconds;
		logic [31:0] local_seconds;
	} in_item_t;

	// Result payload
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] sample_offset;
		logic signed [31:0] median_offset;
		logic [3:0]         samples_held;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_ALARM       = 2'd1,
		ST_BAD_STRATUM = 2'd2
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] REG_STRATUM_LIMIT = 2'd0;
	localparam logic [1:0] REG_WINDOW_LIMIT  = 2'd1;

	localparam logic [3:0]  STRATUM_LIMIT_RST = 4'd14;
	localparam logic [3:0]  WINDOW_LIMIT_RST  = 4'd8;
	localparam logic [31:0] EPOCH_DIFF        = 32'h83aa7e80;
	localparam logic [1:0]  LEAP_ALARM        = 2'd3;

	// Microcode
	typedef logic [3:0] upc_t;

	typedef enum logic [2:0] {
		JMP_NEVER,
		JMP_ALWAYS,
		JMP_REJECT,
		JMP_OVER_LIMIT,
		JMP_MORE
	} jump_t;

	typedef struct packed {
		logic  take_req;
		logic  adj;
		logic  push;
		logic  trim;
		logic  sort_clr;
		logic  mem_rd;
		logic  sort_ins;
		logic  pick;
		logic  calc;
		logic  emit;
		jump_t jump;
		upc_t  target;
	} uword_t;

	localparam upc_t UPC_FETCH    = 4'd0;
	localparam upc_t UPC_CHECK    = 4'd1;
	localparam upc_t UPC_PUSH     = 4'd2;
	localparam upc_t UPC_TRIM     = 4'd3;
	localparam upc_t UPC_SORT_CLR = 4'd4;
	localparam upc_t UPC_READ     = 4'd5;
	localparam upc_t UPC_INSERT   = 4'd6;
	localparam upc_t UPC_PICK     = 4'd7;
	localparam upc_t UPC_CALC     = 4'd8;
	localparam upc_t UPC_EMIT     = 4'd9;

	function automatic uword_t ucode_rom(input upc_t pc);
		uword_t w;
		w        = '0;
		w.jump   = JMP_NEVER;
		w.target = UPC_FETCH;
		unique case (pc)
			UPC_FETCH:    w.take_req = 1'b1;
			UPC_CHECK: begin
				w.adj    = 1'b1;
				w.jump   = JMP_REJECT;
				w.target = UPC_EMIT;
			end
			UPC_PUSH:     w.push = 1'b1;
			UPC_TRIM: begin
				w.trim   = 1'b1;
				w.jump   = JMP_OVER_LIMIT;
				w.target = UPC_TRIM;
			end
			UPC_SORT_CLR: w.sort_clr = 1'b1;
			UPC_READ:     w.mem_rd = 1'b1;
			UPC_INSERT: begin
				w.sort_ins = 1'b1;
				w.jump     = JMP_MORE;
				w.target   = UPC_READ;
			end
			UPC_PICK:     w.pick = 1'b1;
			UPC_CALC:     w.calc = 1'b1;
			UPC_EMIT: begin
				w.emit   = 1'b1;
				w.jump   = JMP_ALWAYS;
				w.target = UPC_FETCH;
			end
			default: begin
				w.jump   = JMP_ALWAYS;
				w.target = UPC_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ntp_offset_median_filter.sv -----
// Sequencing: a rejected reply goes from the check step straight to the emit step;
//   an accepted one is pushed and trimmed to the window limit, then each window
//   sample costs one memory read and one insert step of the sorter, sequenced by
//   microcode, before the pick, calc and emit steps. A new request is taken only
//   once the previous result has been loaded into the result register.
// Reset: arst_n clears the window count, oldest slot and held offset, and
//   restores both limits to their defaults.
// ----------------------------------------------------------------------------
// ntp_offset_median_filter: SNTP offset median filter
// Checks each SNTP reply, forms its clock offset, keeps a circular window of
// the newest offsets and publishes their median as the system offset.
// ----------------------------------------------------------------------------
`default_nettype none

module ntp_offset_median_filter import nomf_pkg::*; #(
	parameter int WINDOW_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [3:0] cfg_data
);

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

	// Sequencer
	upc_t   pc_q, pc_d;
	uword_t uw;
	logic   hold, jump_taken;

	// Configuration
	logic [3:0] stratum_limit_q, window_limit_q;

	// Request capture
	status_t     status_q;
	logic [31:0] sample_q;

	// Window bookkeeping
	logic [CNT_W-1:0] count_q, lim, i_q, i_next;
	logic [IDX_W-1:0] oldest_q, oldest_inc, wr_idx, rd_idx;
	logic [SUM_W-1:0] wr_sum, rd_sum, wr_wrap, rd_wrap;
	logic [4:0]       wl5, lim5, cnt5;
	logic             full, over_limit, more, trim_fire, emit_fire;

	// Window memory and sorter
	logic [31:0]        win_mem [WINDOW_DEPTH];
	logic signed [31:0] rd_data_q;
	logic signed [31:0] sort_q [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] gt, gt_prev;

	// Median arithmetic
	logic [IDX_W-1:0]   mid_idx, lo_idx;
	logic signed [31:0] hi_q, lo_q, current_q;
	logic signed [32:0] sum33, sum_adj;
	logic signed [31:0] even_m, med_m, median_d;

	// Result register
	logic      out_valid_q;
	out_item_t out_q;

	// ------------------------------------------------------------------
	// Configuration port: always ready, a write takes effect in the next cycle
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stratum_limit_q <= STRATUM_LIMIT_RST;
			window_limit_q  <= WINDOW_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STRATUM_LIMIT: stratum_limit_q <= cfg_data;
				REG_WINDOW_LIMIT:  window_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Microcode sequencer: one control word per step, hold on a stalled
	// handshake, otherwise jump on the word's condition or advance
	// ------------------------------------------------------------------
	assign uw       = ucode_rom(pc_q);
	assign in_ready = uw.take_req;

	assign hold = (uw.take_req && !in_valid) || (uw.emit && out_valid_q && !out_ready);

	always_comb begin
		unique case (uw.jump)
			JMP_NEVER:      jump_taken = 1'b0;
			JMP_ALWAYS:     jump_taken = 1'b1;
			JMP_REJECT:     jump_taken = (status_q != ST_OK);
			JMP_OVER_LIMIT: jump_taken = over_limit;
			JMP_MORE:       jump_taken = more;
			default:        jump_taken = 1'b0;
		endcase
	end

	always_comb begin
		if (hold) begin
			pc_d = pc_q;
		end else if (jump_taken) begin
			pc_d = uw.target;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= UPC_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	// ------------------------------------------------------------------
	// Request capture: classify the reply, start the offset subtraction,
	// finish it (minus the epoch difference) in the check step
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			if (in_data.header_word[31:30] == LEAP_ALARM) begin
				status_q <= ST_ALARM;
			end else if (in_data.header_word[23:16] == 8'd0 ||
					in_data.header_word[23:16] > {4'd0, stratum_limit_q}) begin
				status_q <= ST_BAD_STRATUM;
			end else begin
				status_q <= ST_OK;
			end
			sample_q <= in_data.server_recv_seconds - in_data.local_seconds;
		end else if (uw.adj) begin
			sample_q <= sample_q - EPOCH_DIFF;
		end
	end

	// ------------------------------------------------------------------
	// Window bookkeeping: circular store addressed from the oldest slot
	// ------------------------------------------------------------------
	assign wl5  = {1'b0, window_limit_q};
	assign lim5 = (wl5 == 5'd0) ? 5'd1 :
		((wl5 > 5'(WINDOW_DEPTH)) ? 5'(WINDOW_DEPTH) : wl5);
	assign lim  = CNT_W'(lim5);

	assign full       = (count_q == CNT_W'(WINDOW_DEPTH));
	assign over_limit = (count_q > lim);
	assign trim_fire  = uw.trim && over_limit;
	assign i_next     = i_q + 1'b1;
	assign more       = (i_next < count_q);

	assign oldest_inc = (oldest_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	assign wr_sum  = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign wr_wrap = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;
	assign wr_idx  = full ? oldest_q : wr_wrap[IDX_W-1:0];

	assign rd_sum  = SUM_W'(oldest_q) + SUM_W'(i_q);
	assign rd_wrap = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
	assign rd_idx  = rd_wrap[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			oldest_q <= '0;
		end else if (uw.push) begin
			// full window: overwrite the oldest sample
			if (full) begin
				oldest_q <= oldest_inc;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (trim_fire) begin
			// drop the oldest sample until the count fits the limit
			oldest_q <= oldest_inc;
			count_q  <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (uw.sort_clr) begin
			i_q <= '0;
		end else if (uw.sort_ins) begin
			i_q <= i_next;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.push) begin
			win_mem[wr_idx] <= sample_q;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.mem_rd) begin
			rd_data_q <= win_mem[rd_idx];
		end
	end

	// ------------------------------------------------------------------
	// Insertion sorter: a row of lanes, one sample inserted per step.
	// Lanes above the insertion point shift up by one.
	// ------------------------------------------------------------------
	assign gt_prev = gt << 1;

	for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_lane
		logic signed [31:0] prev_val;

		if (g == 0) begin : g_first
			assign prev_val = rd_data_q;
		end else begin : g_rest
			assign prev_val = sort_q[g-1];
		end

		assign gt[g] = (CNT_W'(g) < i_q) && (sort_q[g] > rd_data_q);

		always_ff @(posedge clk) begin
			if (uw.sort_ins) begin
				if (gt_prev[g]) begin
					sort_q[g] <= prev_val;
				end else if (gt[g] || CNT_W'(g) == i_q) begin
					sort_q[g] <= rd_data_q;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Median: pick the middle pair, average it toward zero for an even
	// count, squash a result of plus or minus one to zero
	// ------------------------------------------------------------------
	assign mid_idx = IDX_W'(count_q >> 1);
	assign lo_idx  = (mid_idx == '0) ? '0 : mid_idx - 1'b1;

	always_ff @(posedge clk) begin
		if (uw.pick) begin
			hi_q <= sort_q[mid_idx];
			lo_q <= sort_q[lo_idx];
		end
	end

	assign sum33    = {hi_q[31], hi_q} + {lo_q[31], lo_q};
	assign sum_adj  = sum33 + {32'd0, sum33[32]};
	assign even_m   = sum_adj[32:1];
	assign med_m    = count_q[0] ? hi_q : even_m;
	assign median_d = (med_m == 32'sd1 || med_m == -32'sd1) ? 32'sd0 : med_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= '0;
		end else if (uw.calc) begin
			current_q <= median_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register: load when free or being drained, hold otherwise
	// ------------------------------------------------------------------
	assign emit_fire = uw.emit && !(out_valid_q && !out_ready);
	assign cnt5      = 5'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.status        <= status_q;
			out_q.sample_offset <= (status_q == ST_OK) ? sample_q : 32'd0;
			out_q.median_offset <= current_q;
			out_q.samples_held  <= cnt5[3:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ----- rtl/nomf_chk.sv -----
// ----------------------------------------------------------------------------
// nomf_chk: port checker of the SNTP offset median filter
// Watches the result port and flags results that break the filter rules.
// ----------------------------------------------------------------------------
`default_nettype none

module nomf_chk import nomf_pkg::*; #(
	parameter int WINDOW_DEPTH = 8
) (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Rejected replies carry no sample offset
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.sample_offset == 32'sd0)
		else $error("rejected reply with nonzero sample offset");

	// The published median never sits at plus or minus one
	a_no_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.median_offset != 32'sd1 &&
			out_data.median_offset != -32'sd1)
		else $error("median offset of plus or minus one");

	// An accepted reply leaves at least one sample in the window
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		(WINDOW_DEPTH < 16) && out_valid && out_data.status == ST_OK |->
			out_data.samples_held != 4'd0)
		else $error("accepted reply with empty window");

endmodule

bind ntp_offset_median_filter nomf_chk #(
	.WINDOW_DEPTH(WINDOW_DEPTH)
) u_nomf_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

`default_nettype wire

// ----- dv/tb_ntp_offset_median_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntp_offset_median_filter: self-checking bench for the SNTP median filter
// Drives SNTP reply requests through the valid/ready port under bursty traffic
// and random output stalls. Reprograms both limit registers between phases.
// Checks every result field against an in-bench filter model.
// ----------------------------------------------------------------------------

// Offset filter model plus the queue of results still owed by the block
class offset_filter_scoreboard #(int DEPTH = 8);
	nomf_pkg::out_item_t owed_results[$];
	logic [31:0]         window_store[DEPTH];
	int                  held_count;
	int                  oldest_slot;
	logic signed [31:0]  system_offset;
	logic [3:0]          stratum_limit;
	logic [3:0]          window_limit;
	int                  errors;
	int                  results_checked;

	function new();
		foreach (window_store[i])
			window_store[i] = '0;
		held_count      = 0;
		oldest_slot     = 0;
		system_offset   = '0;
		stratum_limit   = nomf_pkg::STRATUM_LIMIT_RST;
		window_limit    = nomf_pkg::WINDOW_LIMIT_RST;
		errors          = 0;
		results_checked = 0;
	endfunction

	function void apply_register(logic [1:0] index, logic [3:0] value);
		case (index)
			nomf_pkg::REG_STRATUM_LIMIT: stratum_limit = value;
			nomf_pkg::REG_WINDOW_LIMIT:  window_limit  = value;
			default: ;
		endcase
	endfunction

	// Advance the filter by one reply and queue the result it must produce
	function void note_request(nomf_pkg::in_item_t req);
		nomf_pkg::out_item_t want;
		logic [1:0]          leap;
		logic [7:0]          stratum;
		logic [31:0]         sample;
		int                  keep;
		int                  sorted[DEPTH];
		int                  v;
		int                  j;
		int                  mid;
		longint              pair_sum;

		leap    = req.header_word[31:30];
		stratum = req.header_word[23:16];
		want    = '0;
		if (leap == nomf_pkg::LEAP_ALARM) begin
			want.status = nomf_pkg::ST_ALARM;
		end else if (stratum == 8'd0 || stratum > stratum_limit) begin
			want.status = nomf_pkg::ST_BAD_STRATUM;
		end else begin
			want.status        = nomf_pkg::ST_OK;
			sample             = req.server_recv_seconds - req.local_seconds
			                     - nomf_pkg::EPOCH_DIFF;
			want.sample_offset = sample;

			keep = (window_limit == 4'd0) ? 1 :
			       (int'(window_limit) > DEPTH) ? DEPTH : int'(window_limit);
			if (held_count >= DEPTH) begin
				window_store[oldest_slot] = sample;
				oldest_slot = (oldest_slot + 1) % DEPTH;
			end else begin
				window_store[(oldest_slot + held_count) % DEPTH] = sample;
				held_count++;
			end
			while (held_count > keep) begin
				oldest_slot = (oldest_slot + 1) % DEPTH;
				held_count--;
			end

			for (int i = 0; i < held_count; i++) begin
				v = $signed(window_store[(oldest_slot + i) % DEPTH]);
				j = i;
				while (j > 0 && sorted[j - 1] > v) begin
					sorted[j] = sorted[j - 1];
					j--;
				end
				sorted[j] = v;
			end
			mid = sorted[held_count / 2];
			if (held_count % 2 == 0) begin
				pair_sum = longint'(mid) + longint'(sorted[held_count / 2 - 1]);
				mid      = int'(pair_sum / 2);
			end
			if (mid == -1 || mid == 1)
				mid = 0;
			system_offset = mid;
		end
		want.median_offset = system_offset;
		want.samples_held  = 4'(held_count);
		owed_results = {owed_results, want};
	endfunction

	function void check_result(nomf_pkg::out_item_t got);
		nomf_pkg::out_item_t want;
		if (owed_results.size() == 0) begin
			errors++;
			$display("%0t: result with nothing owed: %p", $time, got);
			return;
		end
		want = owed_results[0];
		owed_results.delete(0);
		results_checked++;
		if (got.status !== want.status) begin
			errors++;
			$display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
		end
		if (got.sample_offset !== want.sample_offset) begin
			errors++;
			$display("%0t: sample_offset expected %0d, actual %0d", $time,
			         want.sample_offset, got.sample_offset);
		end
		if (got.median_offset !== want.median_offset) begin
			errors++;
			$display("%0t: median_offset expected %0d, actual %0d", $time,
			         want.median_offset, got.median_offset);
		end
		if (got.samples_held !== want.samples_held) begin
			errors++;
			$display("%0t: samples_held expected %0d, actual %0d", $time,
			         want.samples_held, got.samples_held);
		end
	endfunction

	function int pending();
		return owed_results.size();
	endfunction
endclass

module tb_ntp_offset_median_filter;
	import nomf_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [3:0] cfg_data;

	offset_filter_scoreboard sb;

	// Limit currently programmed, so random replies can aim just inside or outside it
	logic [3:0]  stratum_cap;
	// Center of the offsets sent in the current phase
	logic [31:0] phase_base;

	ntp_offset_median_filter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Observe all three handshakes at the edge; the model sees them in the order
	// result, request, register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (in_valid && in_ready)
				sb.note_request(in_data);
			if (cfg_valid && cfg_ready)
				sb.apply_register(cfg_index, cfg_data);
		end
	end

	// Build a reply whose computed offset is exactly offset; header filler bits random
	function automatic in_item_t sntp_reply(input logic [1:0] leap, input logic [7:0] stratum,
	                                        input logic [31:0] offset,
	                                        input logic [31:0] local_secs);
		in_item_t r;
		r.header_word         = {leap, 6'($urandom), stratum, 16'($urandom)};
		r.local_seconds       = local_secs;
		r.server_recv_seconds = local_secs + EPOCH_DIFF + offset;
		return r;
	endfunction

	// Mostly well-formed replies near the phase offset; the rest rejects and noise
	function automatic in_item_t random_reply();
		int          pick;
		logic [1:0]  leap;
		logic [7:0]  stratum;
		in_item_t    r;
		pick    = $urandom_range(0, 99);
		leap    = 2'($urandom_range(0, 2));
		stratum = (stratum_cap == 4'd0) ? 8'd1 : 8'($urandom_range(1, stratum_cap));
		if (pick < 62)
			r = sntp_reply(leap, stratum, phase_base + $urandom_range(0, 64) - 32, $urandom);
		else if (pick < 70)
			// offsets around zero exercise the forcing of +1 and -1 to 0
			r = sntp_reply(leap, stratum, $urandom_range(0, 4) - 2, $urandom);
		else if (pick < 76)
			r = sntp_reply(leap, stratum, $urandom, $urandom);
		else if (pick < 84)
			r = sntp_reply(LEAP_ALARM, 8'($urandom), $urandom, $urandom);
		else if (pick < 90)
			r = sntp_reply(leap, 8'd0, $urandom, $urandom);
		else if (pick < 96)
			r = sntp_reply(leap, 8'($urandom_range(int'(stratum_cap) + 1, 255)),
			               $urandom, $urandom);
		else begin
			r.header_word         = $urandom;
			r.server_recv_seconds = $urandom;
			r.local_seconds       = $urandom;
		end
		return r;
	endfunction

	// Offer one request and hold it until taken; valid stays high on return
	task automatic send_request(input in_item_t req);
		in_valid <= 1'b1;
		in_data  <= req;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Send count random requests in bursts; gapless phases never drop valid
	task automatic send_phase(input int count, input bit gapless);
		int burst;
		int gap;
		int sent;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_request(random_reply());
				sent++;
			end
			gap = gapless ? 0 : $urandom_range(0, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Wait until every owed result is back, then let the sequencer go quiet
	task automatic settle();
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic program_register(input logic [1:0] index, input logic [3:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram both limits with the block idle
	task automatic set_limits(input logic [3:0] stratum_lim, input logic [3:0] window_lim);
		settle();
		program_register(REG_STRATUM_LIMIT, stratum_lim);
		program_register(REG_WINDOW_LIMIT, window_lim);
		stratum_cap = stratum_lim;
	endtask

	// Receiver: pick stall patterns at random; twice hold off for a long stretch
	// so the filter fills up and backs up its request port.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int next_hold;
		int tick;
		out_ready <= 1'b0;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		next_hold = 300;
		tick      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (next_hold != 0 && sb.results_checked >= next_hold) begin
				hold_left = 400;
				next_hold = (next_hold == 300) ? 1200 : 0;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			tick++;
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (tick % 5) < 2;
				endcase
			end
		end
	end

	initial begin
		logic [3:0] slim;
		logic [3:0] wlim;
		sb          = new();
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		in_data     <= '0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_STRATUM_LIMIT;
		cfg_data    <= '0;
		stratum_cap = STRATUM_LIMIT_RST;
		phase_base  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: stratum edges, alarm taking priority, offsets at the extremes
		send_request(sntp_reply(2'd0, 8'd0, 5, $urandom));
		send_request(sntp_reply(LEAP_ALARM, 8'd0, 5, $urandom));
		send_request(sntp_reply(LEAP_ALARM, 8'd7, 5, $urandom));
		send_request(sntp_reply(2'd0, 8'd14, 1, $urandom));
		send_request(sntp_reply(2'd1, 8'd1, -1, $urandom));
		send_request(sntp_reply(2'd0, 8'd15, 9, $urandom));
		send_request(sntp_reply(2'd2, 8'd255, 9, $urandom));
		send_request(sntp_reply(2'd0, 8'd1, 32'h7fffffff, 32'hffffffff));
		send_request(sntp_reply(2'd0, 8'd1, 32'h80000000, 32'h00000000));
		send_request(sntp_reply(2'd0, 8'd14, 32'h7fffffff, $urandom));
		send_request(sntp_reply(2'd2, 8'd2, 32'h7ffffffe, $urandom));
		send_request(sntp_reply(2'd0, 8'd7, 32'h80000001, $urandom));
		send_request(sntp_reply(2'd1, 8'd14, -3, $urandom));
		// ninth accepted sample wraps the full window
		send_request(sntp_reply(2'd0, 8'd9, 2, $urandom));
		send_request('1);
		send_request('0);
		in_valid <= 1'b0;

		// Stratum limit zero rejects every non-alarm reply
		set_limits(4'd0, 4'd0);
		send_request(sntp_reply(2'd0, 8'd1, 10, $urandom));
		send_request(sntp_reply(2'd2, 8'd5, -7, $urandom));
		in_valid <= 1'b0;

		// Window limit zero acts as one; the eight held samples collapse to one
		set_limits(4'd15, 4'd0);
		send_request(sntp_reply(2'd0, 8'd15, 1, $urandom));
		send_request(sntp_reply(2'd0, 8'd3, -2, $urandom));
		send_request(sntp_reply(2'd1, 8'd15, 3, $urandom));
		in_valid <= 1'b0;

		// Window limit above the depth is clamped to it
		set_limits(4'd15, 4'd15);
		send_request(sntp_reply(2'd0, 8'd4, 100, $urandom));
		send_request(sntp_reply(2'd0, 8'd4, -100, $urandom));
		send_request(sntp_reply(2'd0, 8'd4, 0, $urandom));
		in_valid <= 1'b0;

		// Random phases, each under its own pair of limits
		for (int p = 0; p < 12; p++) begin
			slim = (p == 3) ? 4'd0 : (p == 5) ? 4'd15 : (p == 8) ? 4'd1 :
			       4'($urandom_range(1, 15));
			case (p % 4)
				0:       wlim = 4'd8;
				1:       wlim = 4'($urandom_range(0, 15));
				2:       wlim = 4'($urandom_range(1, 3));
				default: wlim = 4'd15;
			endcase
			set_limits(slim, wlim);
			case (p % 4)
				2:       phase_base = 32'h80000010;
				3:       phase_base = 32'h7fffffe0;
				default: phase_base = $urandom_range(0, 2000) - 1000;
			endcase
			send_phase(150, (p % 3) == 0);
		end

		settle();
		if (sb.errors == 0)
			$display("ntp_offset_median_filter test passed");
		else
			$display("ntp_offset_median_filter test failed");
		$finish;
	end

	// Hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("ntp_offset_median_filter test failed");
		$finish;
	end

endmodule
